@@ src/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed port widths for the sliding window median block.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Fixed widths of the streaming ports
    localparam int SAMPLE_IN_W = 32;
    localparam int MEDIAN_W    = 32;
    localparam int FILL_W      = 6;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MERGE,
        ST_OUT
    } swm_state_t;

    // Command from the sequencer to the sorted-copy merge unit
    typedef struct packed {
        logic start;  // begin one merge pass
        logic drop;   // window was full: remove the evicted sample
    } swm_merge_cmd_t;

endpackage

@@ src/swm_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ring
// Circular sample store in arrival order. On a write it stores the new sample
// and returns the evicted (oldest) entry on the next cycle.
// ----------------------------------------------------------------------------
module swm_ring #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [SAMPLE_BITS-1:0]           wr_sample,
    output logic [SAMPLE_BITS-1:0]           old_sample,
    output logic [$clog2(WINDOW+1)-1:0]      held_count,
    output logic                             full
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [IDX_W-1:0]       oldest_reg, oldest_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic [IDX_W:0]         slot_sum;
    logic [IDX_W:0]         slot_wrap;
    logic [IDX_W-1:0]       slot;

    assign full = (held_reg == CNT_W'(WINDOW));

    // Pick the slot just past the newest sample, or the oldest one when full
    always_comb begin
        slot_sum  = {1'b0, oldest_reg} + (IDX_W + 1)'(held_reg);
        slot_wrap = (slot_sum >= (IDX_W + 1)'(WINDOW)) ?
                    slot_sum - (IDX_W + 1)'(WINDOW) : slot_sum;
        slot      = full ? oldest_reg : slot_wrap[IDX_W-1:0];
    end

    // Advance the oldest pointer only on eviction, grow the count otherwise
    always_comb begin
        oldest_next = oldest_reg;
        held_next   = held_reg;
        if (wr_en) begin
            if (full) begin
                oldest_next = (oldest_reg == IDX_W'(WINDOW - 1)) ?
                              '0 : oldest_reg + 1'b1;
            end else begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            held_reg   <= '0;
        end else begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
        end
    end

    // Read the oldest entry before it is overwritten in the same cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            old_reg   <= mem[oldest_reg];
            mem[slot] <= wr_sample;
        end
    end

    assign old_sample = old_reg;
    assign held_count = held_reg;

endmodule

@@ src/swm_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_sorter
// Sorted copy of the window in two ping-pong banks. One merge pass walks the
// source bank with a single compare unit, drops the evicted sample, inserts
// the new one into the other bank and captures the two middle entries.
// ----------------------------------------------------------------------------
module swm_sorter #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  swm_pkg::swm_merge_cmd_t      cmd,
    input  logic [$clog2(WINDOW+1)-1:0]  n_new,
    input  logic [SAMPLE_BITS-1:0]       new_sample,
    input  logic [SAMPLE_BITS-1:0]       old_sample,
    output logic                         done,
    output logic [SAMPLE_BITS-1:0]       mid_lo,
    output logic [SAMPLE_BITS-1:0]       mid_hi
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] bank0 [WINDOW];
    logic [SAMPLE_BITS-1:0] bank1 [WINDOW];
    logic [SAMPLE_BITS-1:0] rd0_reg, rd1_reg;

    logic                   busy_reg, busy_next;
    logic                   sel_reg, sel_next;
    logic                   inserted_reg, inserted_next;
    logic                   removed_reg, removed_next;
    logic                   done_reg, done_next;
    logic                   drop_reg, drop_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]       wr_cnt_reg, wr_cnt_next;
    logic [SAMPLE_BITS-1:0] lo_reg, hi_reg;

    logic [CNT_W-1:0]       n_old;
    logic [CNT_W-1:0]       k_lo, k_hi;
    logic                   exhausted;
    logic [SAMPLE_BITS-1:0] head;
    logic                   take_new;
    logic                   take_drop;
    logic                   wr_en;
    logic [SAMPLE_BITS-1:0] wr_val;

    // Entries held before this item, and the middle positions after it
    assign n_old = drop_reg ? n_new : n_new - 1'b1;
    assign k_lo  = (n_new - 1'b1) >> 1;
    assign k_hi  = n_new >> 1;

    assign head      = sel_reg ? rd1_reg : rd0_reg;
    assign exhausted = (rd_cnt_reg >= n_old);

    // Shared compare unit: insert point and eviction match
    assign take_new  = !inserted_reg && (exhausted || (new_sample <= head));
    assign take_drop = !take_new && drop_reg && !removed_reg && (head == old_sample);
    assign wr_en     = busy_reg && !take_drop;
    assign wr_val    = take_new ? new_sample : head;

    // Step the merge walk
    always_comb begin
        busy_next     = busy_reg;
        sel_next      = sel_reg;
        inserted_next = inserted_reg;
        removed_next  = removed_reg;
        drop_next     = drop_reg;
        rd_cnt_next   = rd_cnt_reg;
        wr_cnt_next   = wr_cnt_reg;
        done_next     = 1'b0;
        if (cmd.start) begin
            busy_next     = 1'b1;
            inserted_next = 1'b0;
            removed_next  = 1'b0;
            drop_next     = cmd.drop;
            rd_cnt_next   = '0;
            wr_cnt_next   = '0;
        end else if (busy_reg) begin
            if (take_new) begin
                inserted_next = 1'b1;
            end else begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (take_drop) begin
                    removed_next = 1'b1;
                end
            end
            if (wr_en) begin
                wr_cnt_next = wr_cnt_reg + 1'b1;
                if (wr_cnt_reg == n_new - 1'b1) begin
                    busy_next = 1'b0;
                    sel_next  = !sel_reg;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            sel_reg      <= 1'b0;
            inserted_reg <= 1'b0;
            removed_reg  <= 1'b0;
            done_reg     <= 1'b0;
            drop_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
        end else begin
            busy_reg     <= busy_next;
            sel_reg      <= sel_next;
            inserted_reg <= inserted_next;
            removed_reg  <= removed_next;
            done_reg     <= done_next;
            drop_reg     <= drop_next;
            rd_cnt_reg   <= rd_cnt_next;
            wr_cnt_reg   <= wr_cnt_next;
        end
    end

    // Read both banks at the next walk position, write the destination bank
    always_ff @(posedge aclk) begin
        rd0_reg <= bank0[rd_cnt_next[IDX_W-1:0]];
        rd1_reg <= bank1[rd_cnt_next[IDX_W-1:0]];
        if (wr_en && sel_reg) begin
            bank0[wr_cnt_reg[IDX_W-1:0]] <= wr_val;
        end
        if (wr_en && !sel_reg) begin
            bank1[wr_cnt_reg[IDX_W-1:0]] <= wr_val;
        end
    end

    // Capture the middle pair as it streams past
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_cnt_reg == k_lo)) begin
            lo_reg <= wr_val;
        end
        if (wr_en && (wr_cnt_reg == k_hi)) begin
            hi_reg <= wr_val;
        end
    end

    assign done   = done_reg;
    assign mid_lo = lo_reg;
    assign mid_hi = hi_reg;

endmodule

@@ src/sliding_window_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the most recent WINDOW samples.
// ----------------------------------------------------------------------------
// Each accepted sample enters a circular store (evicting the oldest one once
// WINDOW samples are held) and a sorted copy of the window is rebuilt by one
// merge pass that walks the previous sorted copy one entry per cycle, pausing
// in the step that inserts the new sample, through a single compare unit.
// From its transfer, an item passes through the load state, the merge pass
// (writing one entry per step, with a step that skips the evicted sample once
// the window is full), the registered finish flag, the output state and the
// output register before its result is offered. A full window skips that
// step when the evicted sample sorts last, since the walk ends before it
// reaches that entry. The next input transfer can be taken in the same cycle
// that the result is offered. The input is not ready while an item is in
// flight; a finished result waits in the output register and does not hold
// off the next input transfer. An even count reports the floor mean of the
// middle pair, formed with one extra sum bit. No clearing pass is needed
// after reset: only written entries ever affect a result.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [swm_pkg::SAMPLE_IN_W-1:0]   s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [swm_pkg::MEDIAN_W-1:0]      m_median,
    output logic [swm_pkg::FILL_W-1:0]        m_fill_count
);

    localparam int CNT_W = $clog2(WINDOW + 1);

    swm_pkg::swm_state_t     state_reg, state_next;
    swm_pkg::swm_merge_cmd_t merge_cmd;

    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    drop_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [swm_pkg::MEDIAN_W-1:0] m_median_reg;
    logic [swm_pkg::FILL_W-1:0]   m_fill_reg;

    logic                    in_xfer;
    logic                    out_load;
    logic [SAMPLE_BITS-1:0]  sample_in;
    logic [SAMPLE_BITS+swm_pkg::SAMPLE_IN_W-1:0] sample_wide;
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic [CNT_W-1:0]        held_count;
    logic                    ring_full;
    logic                    merge_done;
    logic [SAMPLE_BITS-1:0]  mid_lo, mid_hi;
    logic [SAMPLE_BITS:0]    mid_sum;
    logic [SAMPLE_BITS+swm_pkg::MEDIAN_W-1:0] median_wide;
    logic [CNT_W+swm_pkg::FILL_W-1:0]         fill_wide;

    // Keep only the low SAMPLE_BITS bits of the incoming sample
    assign sample_wide = {{SAMPLE_BITS{1'b0}}, s_sample};
    assign sample_in   = sample_wide[SAMPLE_BITS-1:0];

    assign in_xfer  = s_valid && s_ready;
    assign out_load = (state_reg == swm_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    swm_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (in_xfer),
        .wr_sample  (sample_in),
        .old_sample (old_sample),
        .held_count (held_count),
        .full       (ring_full)
    );

    swm_sorter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sorter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (merge_cmd),
        .n_new      (held_count),
        .new_sample (sample_reg),
        .old_sample (old_sample),
        .done       (merge_done),
        .mid_lo     (mid_lo),
        .mid_hi     (mid_hi)
    );

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = swm_pkg::ST_LOAD;
                end
            end
            swm_pkg::ST_LOAD: begin
                state_next = swm_pkg::ST_MERGE;
            end
            swm_pkg::ST_MERGE: begin
                if (merge_done) begin
                    state_next = swm_pkg::ST_OUT;
                end
            end
            swm_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_ready         = 1'b0;
        merge_cmd.start = 1'b0;
        merge_cmd.drop  = drop_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:  s_ready = 1'b1;
            swm_pkg::ST_LOAD:  merge_cmd.start = 1'b1;
            swm_pkg::ST_MERGE: merge_cmd.start = 1'b0;
            swm_pkg::ST_OUT:   merge_cmd.start = 1'b0;
            default:           s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the new sample and whether it evicts one
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= sample_in;
            drop_reg   <= ring_full;
        end
    end

    // Floor mean of the middle pair; an odd count gives the same entry twice
    assign mid_sum     = {1'b0, mid_lo} + {1'b0, mid_hi};
    assign median_wide = {{swm_pkg::MEDIAN_W{1'b0}}, mid_sum[SAMPLE_BITS:1]};
    assign fill_wide   = {{swm_pkg::FILL_W{1'b0}}, held_count};

    // Output register: load the result, drop valid on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_median_reg <= median_wide[swm_pkg::MEDIAN_W-1:0];
            m_fill_reg   <= fill_wide[swm_pkg::FILL_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_median     = m_median_reg;
    assign m_fill_count = m_fill_reg;

    // Merge completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        merge_done |-> (state_reg == swm_pkg::ST_MERGE))
        else $error("merge finished outside the merge state");

    // A merge pass starts in the cycle after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        merge_cmd.start |-> $past(in_xfer))
        else $error("merge started without a preceding transfer");

    // The held count never exceeds the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count <= CNT_W'(WINDOW))
        else $error("held count beyond window size");

    // A fresh result appears only from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == swm_pkg::ST_OUT))
        else $error("result raised outside the output state");

    // While a result is offered the window holds at least one sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (held_count != '0))
        else $error("result offered with an empty window");

endmodule

@@ tb/sv/tb_sliding_window_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median
// Self-checking bench for the running median over the last WINDOW samples.
// ----------------------------------------------------------------------------
// A queue of samples, filled up front, feeds a clocked driver on the s_
// channel. Every input transfer updates a local copy of the sample window and
// pushes the expected median and fill count. A clocked monitor on the m_
// channel compares each result transfer with the oldest expectation. The run
// starts with a few directed edge values, then three random phases of sender
// and receiver back-pressure (none in the last), with occasional full drains.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

    localparam int WINDOW_LEN  = 50;
    localparam int SAMPLE_BITS = 32;
    localparam int SW = swm_pkg::SAMPLE_IN_W;
    localparam int MW = swm_pkg::MEDIAN_W;
    localparam int FW = swm_pkg::FILL_W;
    // Tail wait after both queues empty, sized from the window length
    localparam int TAIL_CYCLES = WINDOW_LEN + 20;

    typedef struct {
        logic [SW-1:0] sample;
        int unsigned   gap_pct;
        int unsigned   stall_pct;
        bit            hold_for_drain;
    } sample_item_t;

    typedef struct {
        logic [MW-1:0] median;
        logic [FW-1:0] fill_count;
    } median_result_t;

    logic          aclk;
    logic          aresetn      = 1'b0;
    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [SW-1:0] s_sample     = '0;
    logic          m_valid;
    logic          m_ready      = 1'b0;
    logic [MW-1:0] m_median;
    logic [FW-1:0] m_fill_count;

    sample_item_t   pending_samples[$];
    median_result_t expected_medians[$];

    // Local copy of the sample window
    logic [SW-1:0]  window_store[WINDOW_LEN];
    int unsigned    oldest_slot  = 0;
    int unsigned    held_samples = 0;

    int unsigned    transfers_done = 0;
    int unsigned    results_done   = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    error_count    = 0;

    // Stimulus phase settings, used while the queue is filled
    int unsigned    cur_gap_pct    = 0;
    int unsigned    cur_stall_pct  = 0;
    logic [SW-1:0]  frame_base     = '0;

    sliding_window_median #(
        .WINDOW      (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_median     (m_median),
        .m_fill_count (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Insert one sample into the window and work out the median it yields
    function automatic median_result_t slide_window_median(input logic [SW-1:0] sample);
        logic [SW-1:0]  ordered[WINDOW_LEN];
        logic [SW-1:0]  key;
        logic [SW:0]    pair_sum;
        int unsigned    slot;
        int unsigned    count;
        int unsigned    i;
        int unsigned    j;
        median_result_t res;
        if (held_samples < WINDOW_LEN) begin
            slot = (oldest_slot + held_samples) % WINDOW_LEN;
            window_store[slot] = sample;
            held_samples++;
        end else begin
            // full: overwrite the oldest and advance past it
            window_store[oldest_slot] = sample;
            oldest_slot = (oldest_slot + 1) % WINDOW_LEN;
        end
        count = held_samples;
        for (i = 0; i < count; i++) begin
            ordered[i] = window_store[(oldest_slot + i) % WINDOW_LEN];
        end
        for (i = 1; i < count; i++) begin
            key = ordered[i];
            j = i;
            while (j > 0 && ordered[j - 1] > key) begin
                ordered[j] = ordered[j - 1];
                j--;
            end
            ordered[j] = key;
        end
        if (count % 2 == 0) begin
            // floor mean of the middle pair, one extra bit for the carry
            pair_sum = {1'b0, ordered[count / 2 - 1]} + {1'b0, ordered[count / 2]};
            res.median = pair_sum[SW:1];
        end else begin
            res.median = ordered[count / 2];
        end
        res.fill_count = FW'(count);
        return res;
    endfunction

    task automatic queue_sample(input logic [SW-1:0] sample, input bit hold_for_drain);
        sample_item_t item;
        item.sample         = sample;
        item.gap_pct        = cur_gap_pct;
        item.stall_pct      = cur_stall_pct;
        item.hold_for_drain = hold_for_drain;
        pending_samples.push_back(item);
    endtask

    // Mix of full-range, clustered and frame-time-like values
    function automatic logic [SW-1:0] pick_sample();
        int unsigned mode;
        mode = $urandom_range(99, 0);
        if (mode < 35) begin
            return $urandom;
        end else if (mode < 55) begin
            return SW'($urandom_range(7, 0));
        end else if (mode < 70) begin
            return {SW{1'b1}} - SW'($urandom_range(7, 0));
        end else begin
            if ($urandom_range(31, 0) == 0) begin
                frame_base = $urandom;
            end
            return frame_base + SW'($urandom_range(255, 0));
        end
    endfunction

    task automatic queue_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                      input int unsigned item_count);
        cur_gap_pct   = gap_pct;
        cur_stall_pct = stall_pct;
        queue_sample(pick_sample(), 1'b1);
        for (int unsigned k = 1; k < item_count; k++) begin
            queue_sample(pick_sample(), $urandom_range(49, 0) == 0);
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        cur_gap_pct   = 29;
        cur_stall_pct = 53;
        // max values: even count must carry into the extra sum bit
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0001, 1'b0);
        queue_sample(32'hFFFF_FFFE, 1'b0);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'hAAAA_AAAA, 1'b0);
        queue_sample(32'h5555_5555, 1'b0);
        queue_sample(32'h0000_0001, 1'b0);
        queue_sample(32'h0000_0001, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h0001_0000, 1'b0);
        queue_sample(32'h0000_FFFF, 1'b0);
        queue_sample(32'hFFFF_0000, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h8000_0001, 1'b0);
        frame_base = $urandom;
        queue_random_phase(29, 53, 380);
        queue_random_phase(53, 29, 380);
        queue_random_phase(0, 0, 390);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_samples.size() != 0 || expected_medians.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_medians.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_medians.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("%0t: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

    // Drive samples; hold valid and payload until the transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_medians.push_back(slide_window_median(s_sample));
                transfers_done++;
                void'(pending_samples.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0
                    && !(pending_samples[0].hold_for_drain && transfers_done != results_done)
                    && $urandom_range(99, 0) >= pending_samples[0].gap_pct) begin
                    s_valid        <= 1'b1;
                    s_sample       <= pending_samples[0].sample;
                    recv_stall_pct <= pending_samples[0].stall_pct;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_done <= results_done + 1;
                if (expected_medians.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got median %h fill %0d",
                             $time, m_median, m_fill_count);
                    error_count++;
                end else begin
                    if (m_median !== expected_medians[0].median) begin
                        $display("%0t: median mismatch: expected %h, got %h", $time,
                                 expected_medians[0].median, m_median);
                        error_count++;
                    end
                    if (m_fill_count !== expected_medians[0].fill_count) begin
                        $display("%0t: fill_count mismatch: expected %0d, got %0d", $time,
                                 expected_medians[0].fill_count, m_fill_count);
                        error_count++;
                    end
                    void'(expected_medians.pop_front());
                end
            end
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

endmodule
